[rtl/csg_pkg.sv]
// ----------------------------------------------------------------------------
// csg_pkg
// Shared types, constants and the square-root step function for the filled
// circle span generator.
// ----------------------------------------------------------------------------
`default_nettype none

package csg_pkg;

  // Field widths
  localparam int unsigned RADIUS_W = 10;
  localparam int unsigned COORD_W  = 11;
  localparam int unsigned COLOUR_W = 32;
  localparam int unsigned PROD_W   = 2 * RADIUS_W;
  localparam int unsigned REM_W    = RADIUS_W + 2;

  // Largest radius the surface supports
  localparam logic [RADIUS_W-1:0] MAX_RADIUS = 10'd1023;

  // Register indexes of the configuration port
  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_COLOUR = 1'b1;

  // Square-root pipeline shape: one result bit per step
  localparam int unsigned SQ_STEPS     = RADIUS_W;
  localparam int unsigned SQ_PER_STAGE = 2;
  localparam int unsigned SQ_STAGES    = SQ_STEPS / SQ_PER_STAGE;
  localparam int unsigned PREP_STAGES  = 2;

  // Sideband that travels with each word
  typedef struct packed {
    logic                in_range;
    logic [RADIUS_W-1:0] dy;
    logic [RADIUS_W-1:0] radius;
  } csg_side_t;

  // Partial square-root state
  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [RADIUS_W-1:0] root;
    logic [PROD_W-1:0]   rad;
  } csg_sq_t;

  // One digit of the restoring square root: pulls two radicand bits
  function automatic csg_sq_t sqrt_step(input csg_sq_t s);
    csg_sq_t             n;
    logic [REM_W+1:0]    cur;
    logic [REM_W+2:0]    trial;
    cur   = {s.rem, s.rad[PROD_W-1 -: 2]};
    trial = {1'b0, cur} - {3'b000, s.root, 2'b01};
    n.rad = {s.rad[PROD_W-3:0], 2'b00};
    if (!trial[REM_W+2]) begin
      n.rem  = trial[REM_W-1:0];
      n.root = {s.root[RADIUS_W-2:0], 1'b1};
    end else begin
      n.rem  = cur[REM_W-1:0];
      n.root = {s.root[RADIUS_W-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/filled_circle_span_generator.sv]
// ----------------------------------------------------------------------------
// filled_circle_span_generator
// Turns a row offset into one horizontal span of a filled circle.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_we writes cfg_wdata into register cfg_index
//   (0 = circle radius, low 10 bits; 1 = fill colour). Write only while
//   no span is in flight.
//   Input: a word (in_row_offset) is taken at each edge with start high;
//   busy stays low, so a new offset can enter every cycle.
//   Output: out_strobe marks each result for exactly one cycle; the
//   receiver must take it then. Offsets outside 1..radius give a word with
//   out_span_valid low and all other fields zero.
//   From start to out_strobe a word passes two front stages (range
//   check, then the 10x11 multiply), five square-root stages of two digits
//   each, and the output register. Throughput is one span per cycle.
//   Reset (rst_n low, synchronous) empties the pipeline and sets the
//   radius to 1 and the colour to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module filled_circle_span_generator (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [csg_pkg::COLOUR_W-1:0] cfg_wdata,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [csg_pkg::RADIUS_W-1:0] in_row_offset,
  output logic                              out_strobe,
  output logic                              out_span_valid,
  output logic [csg_pkg::COORD_W-1:0]       out_lower_row,
  output logic [csg_pkg::RADIUS_W-1:0]      out_upper_row,
  output logic [csg_pkg::COORD_W-1:0]       out_span_start,
  output logic [csg_pkg::COORD_W-1:0]       out_span_end,
  output logic [csg_pkg::COLOUR_W-1:0]      out_pixel_value
);
  import csg_pkg::*;

  localparam int unsigned LATENCY = PREP_STAGES + SQ_STAGES + 1;

  logic [RADIUS_W-1:0] radius_r;
  logic [COLOUR_W-1:0] colour_r;
  logic                accept;
  logic                p_valid;
  csg_side_t           p_side;
  csg_sq_t             p_sq;
  logic                q_valid;
  csg_side_t           q_side;
  logic [RADIUS_W-1:0] q_root;
  logic [COORD_W-1:0]  two_r;
  logic [COORD_W-1:0]  end_raw;
  logic [COORD_W-1:0]  end_lim;
  logic                ok_nxt;
  logic [COORD_W-1:0]  lower_nxt, start_nxt, end_nxt;
  logic [RADIUS_W-1:0] upper_nxt;
  logic [COLOUR_W-1:0] pixel_nxt;
  logic                strobe_r;
  logic                ok_r;
  logic [COORD_W-1:0]  lower_r, start_r, end_r;
  logic [RADIUS_W-1:0] upper_r;
  logic [COLOUR_W-1:0] pixel_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_W'(1);
      colour_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS: radius_r <= cfg_wdata[RADIUS_W-1:0];
        CFG_COLOUR: colour_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Fully pipelined: never busy
  assign busy   = 1'b0;
  assign accept = start && !busy;

  csg_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_dy     (in_row_offset),
    .radius    (radius_r),
    .out_valid (p_valid),
    .out_side  (p_side),
    .out_sq    (p_sq)
  );

  csg_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_valid),
    .in_side   (p_side),
    .in_sq     (p_sq),
    .out_valid (q_valid),
    .out_side  (q_side),
    .out_root  (q_root)
  );

  // Span ends; end clamps to 2R-1 on the full-width row
  always_comb begin
    ok_nxt    = q_side.in_range;
    two_r     = {q_side.radius, 1'b0};
    end_raw   = {1'b0, q_side.radius} + {1'b0, q_root};
    end_lim   = two_r - COORD_W'(1);
    lower_nxt = '0;
    upper_nxt = '0;
    start_nxt = '0;
    end_nxt   = '0;
    pixel_nxt = '0;
    if (ok_nxt) begin
      lower_nxt = two_r - {1'b0, q_side.dy};
      upper_nxt = q_side.dy;
      start_nxt = {1'b0, q_side.radius} - {1'b0, q_root};
      end_nxt   = (end_raw > end_lim) ? end_lim : end_raw;
      pixel_nxt = colour_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    ok_r    <= ok_nxt;
    lower_r <= lower_nxt;
    upper_r <= upper_nxt;
    start_r <= start_nxt;
    end_r   <= end_nxt;
    pixel_r <= pixel_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_span_valid  = ok_r;
  assign out_lower_row   = lower_r;
  assign out_upper_row   = upper_r;
  assign out_span_start  = start_r;
  assign out_span_end    = end_r;
  assign out_pixel_value = pixel_r;

  // Every result traces back to a word taken a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LATENCY))
    else $error("result without matching input word");

  // A valid span never runs backwards
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_span_valid) |-> (out_span_start <= out_span_end))
    else $error("span start past span end");

  // Mirrored rows sum to the diameter
  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_span_valid)
      |-> ({1'b0, out_lower_row} + {2'b00, out_upper_row} == {1'b0, radius_r, 1'b0}))
    else $error("mirrored rows do not sum to 2R");

  // Span is centered on the radius column unless its end sits at 2R-1
  a_center: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_span_valid && (out_span_end != {radius_r, 1'b0} - COORD_W'(1)))
      |-> ({1'b0, out_span_start} + {1'b0, out_span_end} == {1'b0, radius_r, 1'b0}))
    else $error("span not centered");

  // Out-of-range words carry all-zero fields
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_span_valid)
      |-> (out_lower_row == '0 && out_upper_row == '0 && out_span_start == '0
           && out_span_end == '0 && out_pixel_value == '0))
    else $error("invalid word carries nonzero fields");

endmodule

`default_nettype wire

[rtl/csg_prep.sv]
// ----------------------------------------------------------------------------
// csg_prep
// Front of the pipeline: range check, 2R-dy, then the dy*(2R-dy) product.
// ----------------------------------------------------------------------------
`default_nettype none

module csg_prep (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [csg_pkg::RADIUS_W-1:0] in_dy,
  input  wire logic [csg_pkg::RADIUS_W-1:0] radius,
  output logic                              out_valid,
  output csg_pkg::csg_side_t                out_side,
  output csg_pkg::csg_sq_t                  out_sq
);
  import csg_pkg::*;

  logic                      a_valid_r;
  csg_side_t                 a_side_r, a_side_nxt;
  logic [COORD_W-1:0]        a_span_r, a_span_nxt;
  logic                      b_valid_r;
  csg_side_t                 b_side_r;
  logic [PROD_W-1:0]         b_prod_r;
  logic [RADIUS_W-1:0]       r_sat;
  logic [RADIUS_W+COORD_W-1:0] prod_full;

  // Stage A: saturate radius, check offset, form 2R-dy
  always_comb begin
    r_sat               = (radius > MAX_RADIUS) ? MAX_RADIUS : radius;
    a_side_nxt.radius   = r_sat;
    a_side_nxt.dy       = in_dy;
    a_side_nxt.in_range = (in_dy != '0) && (in_dy <= r_sat);
    a_span_nxt          = {r_sat, 1'b0} - {1'b0, in_dy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_side_r <= a_side_nxt;
    a_span_r <= a_span_nxt;
  end

  // Stage B: radicand dy*(2R-dy), at most R*R
  assign prod_full = a_side_r.dy * a_span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    b_side_r <= a_side_r;
    b_prod_r <= prod_full[PROD_W-1:0];
  end

  assign out_valid   = b_valid_r;
  assign out_side    = b_side_r;
  assign out_sq.rem  = '0;
  assign out_sq.root = '0;
  assign out_sq.rad  = b_prod_r;

endmodule

`default_nettype wire

[rtl/csg_sqrt.sv]
// ----------------------------------------------------------------------------
// csg_sqrt
// Pipelined integer square root, two result bits per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module csg_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire csg_pkg::csg_side_t           in_side,
  input  wire csg_pkg::csg_sq_t             in_sq,
  output logic                              out_valid,
  output csg_pkg::csg_side_t                out_side,
  output logic [csg_pkg::RADIUS_W-1:0]      out_root
);
  import csg_pkg::*;

  logic      stg_valid_r [SQ_STAGES];
  csg_side_t stg_side_r  [SQ_STAGES];
  csg_sq_t   stg_sq_r    [SQ_STAGES];
  logic      src_valid   [SQ_STAGES];
  csg_side_t src_side    [SQ_STAGES];
  csg_sq_t   src_sq      [SQ_STAGES];
  csg_sq_t   stg_sq_nxt  [SQ_STAGES];

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
    // Stage input: pipeline entry or previous stage
    if (g == 0) begin : g_first
      assign src_valid[g] = in_valid;
      assign src_side[g]  = in_side;
      assign src_sq[g]    = in_sq;
    end else begin : g_next
      assign src_valid[g] = stg_valid_r[g-1];
      assign src_side[g]  = stg_side_r[g-1];
      assign src_sq[g]    = stg_sq_r[g-1];
    end

    // Digit steps of this stage
    always_comb begin
      csg_sq_t s;
      s = src_sq[g];
      for (int k = 0; k < SQ_PER_STAGE; k++) begin
        s = sqrt_step(s);
      end
      stg_sq_nxt[g] = s;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_valid_r[g] <= 1'b0;
      end else begin
        stg_valid_r[g] <= src_valid[g];
      end
    end

    always_ff @(posedge clk) begin
      stg_side_r[g] <= src_side[g];
      stg_sq_r[g]   <= stg_sq_nxt[g];
    end
  end

  assign out_valid = stg_valid_r[SQ_STAGES-1];
  assign out_side  = stg_side_r[SQ_STAGES-1];
  assign out_root  = stg_sq_r[SQ_STAGES-1].root;

endmodule

`default_nettype wire

[verif/filled_circle_span_generator_tb.sv]
// ----------------------------------------------------------------------------
// filled_circle_span_generator_tb
// Self-checking bench for the filled circle span generator. A built-in
// predictor computes each expected span, using an exact integer square root
// of dy*(2R-dy). A monitor compares every strobed word field by field with
// the oldest pending prediction. Stimulus is a short directed set covering
// reset values, extreme radii, radius zero and the full-width row, followed
// by random offsets over many radius/colour settings under three sender
// idle profiles.
// ----------------------------------------------------------------------------
`default_nettype none

module filled_circle_span_generator_tb;

  import csg_pkg::*;

  localparam int LATENCY        = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEMS_PER_SET  = 60;
  localparam int SETS_PER_MODE  = 8;
  localparam int MAX_PRINTS     = 40;

  // One expected span word
  typedef struct packed {
    logic                valid;
    logic [COORD_W-1:0]  lower_row;
    logic [RADIUS_W-1:0] upper_row;
    logic [COORD_W-1:0]  first_col;
    logic [COORD_W-1:0]  last_col;
    logic [COLOUR_W-1:0] pixel;
  } span_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic                cfg_index;
  logic [COLOUR_W-1:0] cfg_wdata;
  logic                start;
  logic                busy;
  logic [RADIUS_W-1:0] in_row_offset;
  logic                out_strobe;
  logic                out_span_valid;
  logic [COORD_W-1:0]  out_lower_row;
  logic [RADIUS_W-1:0] out_upper_row;
  logic [COORD_W-1:0]  out_span_start;
  logic [COORD_W-1:0]  out_span_end;
  logic [COLOUR_W-1:0] out_pixel_value;

  // Shadow copy of the configuration
  logic [RADIUS_W-1:0] radius_q;
  logic [COLOUR_W-1:0] colour_q;

  span_t pending_spans[$];

  int error_count   = 0;
  int offsets_sent  = 0;
  int spans_checked = 0;
  int valid_spans   = 0;
  int settings_used = 0;
  int idle_pct      = 0;
  int quiet_cycles  = 0;

  filled_circle_span_generator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_row_offset   (in_row_offset),
    .out_strobe      (out_strobe),
    .out_span_valid  (out_span_valid),
    .out_lower_row   (out_lower_row),
    .out_upper_row   (out_upper_row),
    .out_span_start  (out_span_start),
    .out_span_end    (out_span_end),
    .out_pixel_value (out_pixel_value)
  );

  always #10 clk = ~clk;

  // Floor of sqrt(v), built one root bit at a time from the top
  function automatic int unsigned floor_root(input int unsigned v);
    int unsigned r;
    int unsigned c;
    int          b;
    r = 0;
    for (b = 10; b >= 0; b--) begin
      c = r | (32'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // Span for one offset under the current radius and colour
  function automatic span_t predict_span(input logic [RADIUS_W-1:0] radius,
                                         input logic [COLOUR_W-1:0] colour,
                                         input logic [RADIUS_W-1:0] dy);
    span_t       s;
    int unsigned r;
    int unsigned d;
    int unsigned half;
    int unsigned last;
    s = '0;
    r = radius;
    d = dy;
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    // offset outside 1..R: invalid word, all fields zero
    if (d == 0 || d > r) return s;
    half = floor_root(d * (2 * r - d));
    last = r + half;
    // full-width row would run one pixel off the surface
    if (last > 2 * r - 1) last = 2 * r - 1;
    s.valid     = 1'b1;
    s.lower_row = COORD_W'(2 * r - d);
    s.upper_row = RADIUS_W'(d);
    s.first_col = COORD_W'(r - half);
    s.last_col  = COORD_W'(last);
    s.pixel     = colour;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTS)
      $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Send one offset word; start is left high after acceptance
  task automatic send_offset(input logic [RADIUS_W-1:0] dy);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start         <= 1'b1;
    in_row_offset <= dy;
    do @(posedge clk); while (busy);
    pending_spans.push_back(predict_span(radius_q, colour_q, dy));
    offsets_sent++;
  endtask

  // Drop start and wait until every pending span has come out
  task automatic drain_spans();
    @(negedge clk);
    start <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [COLOUR_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_RADIUS) radius_q = data[RADIUS_W-1:0];
    else colour_q = data;
  endtask

  // New radius and colour once the pipe is empty; upper data bits are junk
  task automatic apply_setting(input logic [RADIUS_W-1:0] radius,
                               input logic [COLOUR_W-1:0] colour);
    drain_spans();
    repeat (LATENCY) @(posedge clk);
    write_reg(CFG_RADIUS, ($urandom & 32'hFFFF_FC00) | COLOUR_W'(radius));
    write_reg(CFG_COLOUR, colour);
    settings_used++;
  endtask

  // Reset values: radius 1, colour 0
  task automatic test_reset_values();
    send_offset(10'd0);
    send_offset(10'd1);
    send_offset(10'd2);
    send_offset(10'd1023);
  endtask

  // Extreme radii, radius zero, full-width rows and their neighbors
  task automatic test_directed_spans();
    apply_setting(10'd1023, 32'hFFFF_FFFF);
    send_offset(10'd1);
    send_offset(10'd2);
    send_offset(10'd511);
    send_offset(10'd1022);
    send_offset(10'd1023);
    apply_setting(10'd0, 32'h1234_5678);
    send_offset(10'd0);
    send_offset(10'd1);
    send_offset(10'd1023);
    apply_setting(10'd512, 32'hA5A5_5A5A);
    send_offset(10'd256);
    send_offset(10'd511);
    send_offset(10'd512);
    send_offset(10'd513);
    apply_setting(10'd2, 32'h0000_0001);
    send_offset(10'd1);
    send_offset(10'd2);
    send_offset(10'd3);
  endtask

  // Random offsets, mostly in range, across many settings and idle profiles
  task automatic test_random_spans();
    int               modes[3] = '{8, 70, 0};
    int               m;
    int               k;
    int               n;
    int               pick;
    logic [RADIUS_W-1:0] radius;
    logic [COLOUR_W-1:0] colour;
    logic [RADIUS_W-1:0] dy;
    for (m = 0; m < 3; m++) begin
      idle_pct = modes[m];
      for (k = 0; k < SETS_PER_MODE; k++) begin
        case (k)
          0: begin radius = 10'd1023; colour = 32'hFFFF_FFFF; end
          1: begin radius = 10'd1;    colour = 32'h0;         end
          2: begin radius = 10'd0;    colour = $urandom;      end
          3: begin radius = 10'($urandom_range(16, 2)); colour = $urandom; end
          default: begin
            radius = 10'($urandom_range(1023, 1));
            colour = $urandom;
          end
        endcase
        apply_setting(radius, colour);
        for (n = 0; n < ITEMS_PER_SET; n++) begin
          // hold off once mid-set until the pipe runs dry
          if (m == 0 && k == 4 && n == ITEMS_PER_SET / 2) drain_spans();
          pick = $urandom_range(99);
          if (radius_q != 0 && pick < 75)
            dy = 10'($urandom_range(radius_q, 1));
          else if (pick < 82)
            dy = radius_q;
          else if (pick < 87)
            dy = radius_q + 10'd1;
          else
            dy = 10'($urandom_range(1023, 0));
          send_offset(dy);
        end
      end
    end
  endtask

  // Result checker
  always @(posedge clk) begin : check_spans
    span_t want;
    if (rst_n && out_strobe) begin
      if (pending_spans.size() == 0) begin
        report_mismatch("unexpected word", out_upper_row, 32'h0);
      end else begin
        want = pending_spans.pop_front();
        spans_checked++;
        if (want.valid) valid_spans++;
        if (out_span_valid !== want.valid)
          report_mismatch("span_valid", out_span_valid, want.valid);
        if (out_lower_row !== want.lower_row)
          report_mismatch("lower_row", out_lower_row, want.lower_row);
        if (out_upper_row !== want.upper_row)
          report_mismatch("upper_row", out_upper_row, want.upper_row);
        if (out_span_start !== want.first_col)
          report_mismatch("span_start", out_span_start, want.first_col);
        if (out_span_end !== want.last_col)
          report_mismatch("span_end", out_span_end, want.last_col);
        if (out_pixel_value !== want.pixel)
          report_mismatch("pixel_value", out_pixel_value, want.pixel);
      end
    end
  end

  // Watchdog: too long with no word moving either way
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d spans still pending", pending_spans.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_RADIUS;
    cfg_wdata     = '0;
    start         = 1'b0;
    in_row_offset = '0;
    radius_q      = 10'd1;
    colour_q      = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_values();
    test_directed_spans();
    test_random_spans();

    drain_spans();
    repeat (LATENCY + 4) @(posedge clk);
    if (pending_spans.size() != 0)
      report_mismatch("spans never produced", pending_spans.size(), 32'h0);

    $display("covered %0d offsets over %0d radius/colour settings", offsets_sent,
             settings_used);
    $display("checked %0d spans, %0d in range, %0d mismatches", spans_checked,
             valid_spans, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
